[src/hfap_pkg.sv]
// ----------------------------------------------------------------------------
// Hashed frame address predictor package
// Shared types, register codes and hash helpers for the predictor pipeline.
// ----------------------------------------------------------------------------
package hfap_pkg;

   localparam int MAX_HASHES = 8;
   localparam int LINE_BYTES = 64;
   localparam int LINE_BITS  = $clog2(LINE_BYTES);
   localparam int DIV_STAGES = 64;

   // CityHash constant k2 and the derived multiplier k2 + 16.
   localparam logic [63:0] CITY_K2 = 64'h9ae16a3b2f90404f;
   localparam logic [63:0] CITY_MUL = CITY_K2 + 64'd16;
   localparam logic [31:0] MUL_LO = CITY_MUL[31:0];
   localparam logic [31:0] MUL_HI = CITY_MUL[63:32];

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_HASH_COUNT   = 3'd0,
      REG_USER_PAGES   = 3'd1,
      REG_KERNEL_PAGES = 3'd2,
      REG_SPEC_KIND    = 3'd3,
      REG_ORACLE       = 3'd4,
      REG_PERFECT      = 3'd5
   } reg_index_type;

   // Speculation kind codes.
   localparam logic [1:0] KIND_DATA_ONLY = 2'd1;
   localparam logic [1:0] KIND_PT_ONLY   = 2'd2;

   // Per-hash bookkeeping that travels beside the arithmetic.
   typedef struct packed {
      logic        oracle;
      logic        last;
      logic [2:0]  k;
      logic [11:0] offset;
      logic [47:0] truth;
   } side_type;

   // One word in the hash pipeline.
   typedef struct packed {
      side_type    side;
      logic [63:0] v0;
      logic [63:0] v1;
      logic [63:0] v2;
      logic [31:0] q0;
      logic [31:0] q1;
   } hash_type;

   // Low partial product of x times the multiplier.
   function automatic logic [63:0] pp_lo(input logic [63:0] x);
      return 64'(x[31:0]) * 64'(MUL_LO);
   endfunction

   // Cross partial products; only their low 32 bits reach the result.
   function automatic logic [31:0] pp_cross(input logic [63:0] x);
      logic [31:0] p;
      logic [31:0] q;
      p = x[31:0] * MUL_HI;
      q = x[63:32] * MUL_LO;
      return p + q;
   endfunction

endpackage

[src/hfap_mod.sv]
// ----------------------------------------------------------------------------
// Remainder pipeline
// Restoring remainder of a 64-bit hash by the user page count, one bit a stage.
// ----------------------------------------------------------------------------
module hfap_mod (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [63:0]        in_num,
   input  hfap_pkg::side_type in_side,
   input  logic [35:0]        divisor,
   output logic               out_valid,
   output logic [35:0]        out_rem,
   output hfap_pkg::side_type out_side
);
   import hfap_pkg::*;

   logic               vld_ff  [0:DIV_STAGES-1];
   logic [35:0]        rem_ff  [0:DIV_STAGES-1];
   logic [63:0]        num_ff  [0:DIV_STAGES-1];
   side_type           side_ff [0:DIV_STAGES-1];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic        vld_src;
      logic [35:0] rem_src;
      logic [63:0] num_src;
      side_type    side_src;
      logic [36:0] trial;
      logic [35:0] rem_in;

      if (i == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = '0;
         assign num_src  = in_num;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign num_src  = num_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      // Shift in the next dividend bit and subtract when it fits.
      always_comb begin
         trial = {rem_src, num_src[63]};
         if (trial >= {1'b0, divisor}) begin
            rem_in = 36'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[35:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_src;
         end
         rem_ff[i]  <= rem_in;
         num_ff[i]  <= {num_src[62:0], 1'b0};
         side_ff[i] <= side_src;
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_rem   = rem_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

[src/hashed_frame_address_predictor.sv]
// ----------------------------------------------------------------------------
// Hashed frame address predictor
// Hashes the virtual page of an access to predicted physical prefetch lines.
// ----------------------------------------------------------------------------
// Usage: a request word (virtual address, page-table flag, true physical
// address) is taken when start is high and busy is low. Each request makes
// one prediction per configured hash (at most eight), one oracle line, or
// nothing when its kind is filtered out. Predictions enter the pipeline one
// per cycle, so a request holds the channel while its hashes issue; busy is
// low as its last hash issues so the next request follows at once.
// Results leave on rsp_strobe, at most one word a cycle, in order, the final one of a
// request marked by rsp_last_of_run. Each word passes through the sequencer
// register, fifteen hash stages, the 64-stage remainder pipeline, a compute
// stage, a one-word hold used to mark the last word when the perfect filter
// drops predictions, and the output register. Under the perfect filter a held
// word can wait for the rest of its request. The receiver cannot stall.
// Reset empties the pipeline and restores the register defaults.
// The user must write registers over the APB port only while the block is
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module hashed_frame_address_predictor (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [47:0] req_virtual_address,
   input  logic        req_is_page_table,
   input  logic [47:0] req_true_physical_address,
   output logic        rsp_strobe,
   output logic [47:0] rsp_prefetch_line_address,
   output logic [2:0]  rsp_hash_number,
   output logic        rsp_prediction_correct,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import hfap_pkg::*;

   localparam int HS = 15;

   // Configuration registers.
   logic [3:0]  hash_count_ff;
   logic [35:0] user_pages_ff;
   logic [35:0] kernel_pages_ff;
   logic [1:0]  spec_kind_ff;
   logic        oracle_ff;
   logic        perfect_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_count_ff   <= 4'd1;
         user_pages_ff   <= 36'd1048576;
         kernel_pages_ff <= '0;
         spec_kind_ff    <= '0;
         oracle_ff       <= 1'b0;
         perfect_ff      <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_HASH_COUNT:   hash_count_ff   <= pwdata[3:0];
            REG_USER_PAGES:   user_pages_ff   <= pwdata[35:0];
            REG_KERNEL_PAGES: kernel_pages_ff <= pwdata[35:0];
            REG_SPEC_KIND:    spec_kind_ff    <= pwdata[1:0];
            REG_ORACLE:       oracle_ff       <= pwdata[0];
            REG_PERFECT:      perfect_ff      <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (csr_index)
         REG_HASH_COUNT:   prdata = 64'(hash_count_ff);
         REG_USER_PAGES:   prdata = 64'(user_pages_ff);
         REG_KERNEL_PAGES: prdata = 64'(kernel_pages_ff);
         REG_SPEC_KIND:    prdata = 64'(spec_kind_ff);
         REG_ORACLE:       prdata = 64'(oracle_ff);
         REG_PERFECT:      prdata = 64'(perfect_ff);
         default:          prdata = '0;
      endcase
   end

   // Issue sequencer: one hash index per cycle for the current request.
   logic        active_ff;
   logic [2:0]  k_ff;
   logic [2:0]  lastk_ff;
   logic [35:0] key_ff;
   logic [11:0] offset_ff;
   logic [47:0] truth_ff;
   logic        ioracle_ff;
   logic        accept;
   logic        kind_ok;
   logic        emit;
   logic [3:0]  count_sat;

   assign busy      = active_ff && (k_ff != lastk_ff);
   assign accept    = start && !busy;
   assign kind_ok   = !((req_is_page_table && spec_kind_ff == KIND_DATA_ONLY) ||
                        (!req_is_page_table && spec_kind_ff == KIND_PT_ONLY));
   assign count_sat = (hash_count_ff > 4'(MAX_HASHES)) ? 4'(MAX_HASHES) : hash_count_ff;
   assign emit      = kind_ok && (oracle_ff || count_sat != 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (accept) begin
         active_ff <= emit;
      end else if (active_ff && k_ff == lastk_ff) begin
         active_ff <= 1'b0;
      end
      if (accept) begin
         k_ff       <= '0;
         lastk_ff   <= oracle_ff ? 3'd0 : 3'(count_sat - 4'd1);
         ioracle_ff <= oracle_ff;
         truth_ff   <= req_true_physical_address;
         if (req_is_page_table) begin
            key_ff    <= 36'(req_virtual_address[47:21]);
            offset_ff <= {req_virtual_address[20:12], 3'b000};
         end else begin
            key_ff    <= req_virtual_address[47:12];
            offset_ff <= req_virtual_address[11:0];
         end
      end else begin
         k_ff <= 3'(k_ff + 3'd1);
      end
   end

   // Hash pipeline: CityHash64 of the eight key bytes, multiplies in halves.
   hash_type hs_ff [1:HS];
   hash_type hs_in [1:HS];
   logic     hv_ff [1:HS];
   logic     hv_in [1:HS];

   always_comb begin
      for (int i = 2; i <= HS; i++) begin
         hs_in[i] = hs_ff[i-1];
         hv_in[i] = hv_ff[i-1];
      end
      // Scaled key.
      hv_in[1]              = active_ff;
      hs_in[1]              = '0;
      hs_in[1].side.oracle  = ioracle_ff;
      hs_in[1].side.last    = (k_ff == lastk_ff);
      hs_in[1].side.k       = k_ff;
      hs_in[1].side.offset  = offset_ff;
      hs_in[1].side.truth   = truth_ff;
      hs_in[1].v0           = 64'(key_ff) * 64'({1'b0, k_ff} + 4'd1);
      // a = key + k2, rotations of b = key.
      hs_in[2].v2 = hs_ff[1].v0 + CITY_K2;
      hs_in[2].v1 = hs_ff[1].v0;
      hs_in[2].v0 = {hs_ff[1].v0[36:0], hs_ff[1].v0[63:37]};
      hs_in[3].v1 = {hs_ff[2].v2[24:0], hs_ff[2].v2[63:25]} + hs_ff[2].v1;
      // Both products of the first round.
      hs_in[4].q0 = pp_cross(hs_ff[3].v0);
      hs_in[4].v0 = pp_lo(hs_ff[3].v0);
      hs_in[4].q1 = pp_cross(hs_ff[3].v1);
      hs_in[4].v1 = pp_lo(hs_ff[3].v1);
      hs_in[5].v0 = hs_ff[4].v0 + {hs_ff[4].q0, 32'b0};
      hs_in[5].v1 = hs_ff[4].v1 + {hs_ff[4].q1, 32'b0};
      // c and then u ^ v of the mix.
      hs_in[6].v0 = hs_ff[5].v0 + hs_ff[5].v2;
      hs_in[7].v0 = hs_ff[6].v0 ^ hs_ff[6].v1;
      hs_in[8].q0 = pp_cross(hs_ff[7].v0);
      hs_in[8].v0 = pp_lo(hs_ff[7].v0);
      hs_in[9].v0 = hs_ff[8].v0 + {hs_ff[8].q0, 32'b0};
      // Fold a, then xor with d.
      hs_in[10].v0 = hs_ff[9].v1 ^ (hs_ff[9].v0 ^ (hs_ff[9].v0 >> 47));
      hs_in[11].q0 = pp_cross(hs_ff[10].v0);
      hs_in[11].v0 = pp_lo(hs_ff[10].v0);
      hs_in[12].v0 = hs_ff[11].v0 + {hs_ff[11].q0, 32'b0};
      hs_in[13].v0 = hs_ff[12].v0 ^ (hs_ff[12].v0 >> 47);
      hs_in[14].q0 = pp_cross(hs_ff[13].v0);
      hs_in[14].v0 = pp_lo(hs_ff[13].v0);
      hs_in[15].v0 = hs_ff[14].v0 + {hs_ff[14].q0, 32'b0};
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= HS; i++) begin
         if (reset) begin
            hv_ff[i] <= 1'b0;
         end else begin
            hv_ff[i] <= hv_in[i];
         end
         hs_ff[i] <= hs_in[i];
      end
   end

   // Reduce the hash modulo the user page count.
   logic        mv;
   logic [35:0] mrem;
   side_type    mside;

   hfap_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hv_ff[HS]),
      .in_num    (hs_ff[HS].v0),
      .in_side   (hs_ff[HS].side),
      .divisor   (user_pages_ff),
      .out_valid (mv),
      .out_rem   (mrem),
      .out_side  (mside)
   );

   // Form the prediction and decide whether it passes the filter.
   logic        ev_ff;
   logic [47:0] eline_ff;
   logic [2:0]  ek_ff;
   logic        eok_ff;
   logic        epass_ff;
   logic        elast_ff;
   logic [35:0] hred;
   logic [36:0] frame;
   logic [48:0] pred;
   logic        ok;

   always_comb begin
      hred  = (user_pages_ff == '0) ? '0 : mrem;
      frame = {1'b0, hred} + {1'b0, kernel_pages_ff};
      pred  = {frame, mside.offset};
      ok    = (pred == {1'b0, mside.truth});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff <= 1'b0;
      end else begin
         ev_ff <= mv;
      end
      elast_ff <= mside.last;
      if (mside.oracle) begin
         eline_ff <= {mside.truth[47:LINE_BITS], {LINE_BITS{1'b0}}};
         ek_ff    <= '0;
         eok_ff   <= 1'b1;
         epass_ff <= 1'b1;
      end else begin
         eline_ff <= {pred[47:LINE_BITS], {LINE_BITS{1'b0}}};
         ek_ff    <= mside.k;
         eok_ff   <= ok;
         epass_ff <= !perfect_ff || ok;
      end
   end

   // Hold the newest passing word until it is known whether it is the last.
   logic        hv_hold_ff, hv_hold_in;
   logic        hdone_ff, hdone_in;
   logic [47:0] hline_ff, hline_in;
   logic [2:0]  hk_ff, hk_in;
   logic        hok_ff, hok_in;
   logic        out_v, out_last;

   always_comb begin
      hv_hold_in = hv_hold_ff;
      hdone_in   = hdone_ff;
      hline_in   = hline_ff;
      hk_in      = hk_ff;
      hok_in     = hok_ff;
      out_v      = 1'b0;
      out_last   = 1'b0;
      if (hv_hold_ff && hdone_ff) begin
         out_v      = 1'b1;
         out_last   = 1'b1;
         hv_hold_in = ev_ff && epass_ff;
      end else if (hv_hold_ff) begin
         if (ev_ff && epass_ff) begin
            out_v = 1'b1;
         end else if (ev_ff && elast_ff) begin
            out_v      = 1'b1;
            out_last   = 1'b1;
            hv_hold_in = 1'b0;
         end
      end else begin
         hv_hold_in = ev_ff && epass_ff;
      end
      if (ev_ff && epass_ff) begin
         hv_hold_in = 1'b1;
         hdone_in   = elast_ff;
         hline_in   = eline_ff;
         hk_in      = ek_ff;
         hok_in     = eok_ff;
      end
   end

   logic        ov_ff;
   logic        olast_ff;
   logic [47:0] oline_ff;
   logic [2:0]  ok_ff;
   logic        ocor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_hold_ff <= 1'b0;
         hdone_ff   <= 1'b0;
         ov_ff      <= 1'b0;
      end else begin
         hv_hold_ff <= hv_hold_in;
         hdone_ff   <= hdone_in;
         ov_ff      <= out_v;
      end
      hline_ff <= hline_in;
      hk_ff    <= hk_in;
      hok_ff   <= hok_in;
      olast_ff <= out_last;
      oline_ff <= hline_ff;
      ok_ff    <= hk_ff;
      ocor_ff  <= hok_ff;
   end

   assign rsp_strobe                = ov_ff;
   assign rsp_last_of_run           = olast_ff;
   assign rsp_prefetch_line_address = oline_ff;
   assign rsp_hash_number           = ok_ff;
   assign rsp_prediction_correct    = ocor_ff;

endmodule

[src/hfap_chk.sv]
// ----------------------------------------------------------------------------
// Predictor port checker
// Watches the top-level ports of the predictor over time.
// ----------------------------------------------------------------------------
module hfap_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [47:0] rsp_prefetch_line_address
);
   import hfap_pkg::*;

   // Busy only comes up after a request word was offered.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // Reset empties the pipeline and the sequencer.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("activity right after reset");

   // Every result word is a whole line.
   a_line_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_prefetch_line_address[LINE_BITS-1:0] == '0))
      else $error("result word not line aligned");

   // Busy never lasts more than the largest hash run.
   a_busy_bound: assert property (@(posedge clock) disable iff (reset)
      busy && $past(busy, 1) && $past(busy, 2) && $past(busy, 3) && $past(busy, 4)
      && $past(busy, 5) && $past(busy, 6) |=> !busy)
      else $error("busy held too long");

endmodule

bind hashed_frame_address_predictor hfap_chk u_hfap_chk (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// Hashed frame address predictor testbench
// Drives request words through the command handshake and writes the registers
// over APB between phases. A scoreboard class recomputes every prediction
// with its own CityHash64 and checks each response word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import hfap_pkg::*;

   localparam logic [1:0] KIND_BOTH  = 2'd0;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int DRAIN_CYCLES = 150;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [63:0] PAGES_MAX = 64'd34359738368;

   // One expected response word.
   typedef struct {
      logic [47:0] line;
      logic [2:0]  hash_num;
      logic        hit;
      logic        last;
   } line_pred_type;

   // Register copy, predictor and store of expected prefetch lines.
   class prefetch_scoreboard;
      logic [3:0]  hash_count;
      logic [35:0] user_pages;
      logic [35:0] kernel_pages;
      logic [1:0]  kind;
      logic        oracle;
      logic        perfect;
      line_pred_type lines[$];
      int errors;

      function void restore_defaults();
         hash_count = 4'd1;
         user_pages = 36'd1048576;
         kernel_pages = 36'd0;
         kind = KIND_BOTH;
         oracle = 1'b0;
         perfect = 1'b0;
      endfunction

      function void set_reg(reg_index_type idx, logic [63:0] value);
         case (idx)
            REG_HASH_COUNT:   hash_count = value[3:0];
            REG_USER_PAGES:   user_pages = value[35:0];
            REG_KERNEL_PAGES: kernel_pages = value[35:0];
            REG_SPEC_KIND:    kind = value[1:0];
            REG_ORACLE:       oracle = value[0];
            REG_PERFECT:      perfect = value[0];
            default: ;
         endcase
      endfunction

      function logic [63:0] rotr(logic [63:0] v, int s);
         return (v >> s) | (v << (64 - s));
      endfunction

      // CityHash64 of the eight bytes of a 64-bit key.
      function logic [63:0] city_hash(logic [63:0] key);
         logic [63:0] mul, a, c, d, x, y;
         mul = CITY_K2 + 64'd16;
         a = key + CITY_K2;
         c = rotr(key, 37) * mul + a;
         d = (rotr(a, 25) + key) * mul;
         x = (c ^ d) * mul;
         x = x ^ (x >> 47);
         y = (d ^ x) * mul;
         y = y ^ (y >> 47);
         return y * mul;
      endfunction

      // Full predicted physical address of hash k.
      function logic [63:0] predict_addr(logic [47:0] va, logic pt, int k);
         logic [63:0] key, offset, h;
         key = pt ? 64'(va >> 21) : 64'(va >> 12);
         offset = pt ? 64'(va[20:12]) * 64'd8 : 64'(va[11:0]);
         h = city_hash(key * 64'(k + 1));
         h = (user_pages != 0) ? h % 64'(user_pages) : 64'd0;
         return ((h + 64'(kernel_pages)) << 12) + offset;
      endfunction

      function void note_request(logic [47:0] va, logic pt, logic [47:0] truth);
         line_pred_type w;
         logic [63:0] p;
         int count;
         int first;
         if (pt && kind == KIND_DATA_ONLY) return;
         if (!pt && kind == KIND_PT_ONLY) return;
         if (oracle) begin
            w.line = {truth[47:6], 6'd0};
            w.hash_num = 3'd0;
            w.hit = 1'b1;
            w.last = 1'b1;
            lines.insert(lines.size(), w);
            return;
         end
         count = (hash_count > MAX_HASHES) ? MAX_HASHES : hash_count;
         first = lines.size();
         for (int k = 0; k < count; k++) begin
            p = predict_addr(va, pt, k);
            if (perfect && p != 64'(truth)) continue;
            w.line = {p[47:6], 6'd0};
            w.hash_num = 3'(k);
            w.hit = (p == 64'(truth));
            w.last = 1'b0;
            lines.insert(lines.size(), w);
         end
         if (lines.size() > first) lines[lines.size() - 1].last = 1'b1;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(logic [47:0] line, logic [2:0] hash_num, logic hit,
                        logic last);
         line_pred_type w;
         if (lines.size() == 0) begin
            report($sformatf("unexpected word line=%h", line));
            return;
         end
         w = lines.pop_front();
         if (line !== w.line)
            report($sformatf("line %h, predicted %h", line, w.line));
         if (hash_num !== w.hash_num)
            report($sformatf("hash number %0d, predicted %0d", hash_num, w.hash_num));
         if (hit !== w.hit)
            report($sformatf("correct flag %b, predicted %b", hit, w.hit));
         if (last !== w.last)
            report($sformatf("last flag %b, predicted %b", last, w.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [47:0] req_virtual_address;
   logic        req_is_page_table;
   logic [47:0] req_true_physical_address;
   logic        rsp_strobe;
   logic [47:0] rsp_prefetch_line_address;
   logic [2:0]  rsp_hash_number;
   logic        rsp_prediction_correct;
   logic        rsp_last_of_run;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [5:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   prefetch_scoreboard sb;
   int cycles;
   int burst_left;

   hashed_frame_address_predictor i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_virtual_address(req_virtual_address),
      .req_is_page_table(req_is_page_table),
      .req_true_physical_address(req_true_physical_address),
      .rsp_strobe(rsp_strobe),
      .rsp_prefetch_line_address(rsp_prefetch_line_address),
      .rsp_hash_number(rsp_hash_number),
      .rsp_prediction_correct(rsp_prediction_correct),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Every response word is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_prefetch_line_address, rsp_hash_number,
                         rsp_prediction_correct, rsp_last_of_run);
   end

   // Register write: setup phase, access phase, then idle.
   task write_reg(reg_index_type idx, logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 6'(idx) * 6'd8;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   // Wait for every expected word, then cover requests with no output.
   task drain();
      while (sb.lines.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task set_config(int hc, logic [63:0] up, logic [63:0] kp, logic [1:0] kind,
                   logic orc, logic pf);
      write_reg(REG_HASH_COUNT, 64'(hc));
      write_reg(REG_USER_PAGES, up);
      write_reg(REG_KERNEL_PAGES, kp);
      write_reg(REG_SPEC_KIND, 64'(kind));
      write_reg(REG_ORACLE, 64'(orc));
      write_reg(REG_PERFECT, 64'(pf));
   endtask

   // Send one request word, with a random gap between bursts.
   task send_request(logic [47:0] va, logic pt, logic [47:0] truth);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_virtual_address <= va;
      req_is_page_table <= pt;
      req_true_physical_address <= truth;
      do @(posedge clock); while (busy);
      sb.note_request(va, pt, truth);
   endtask

   // Random request; often the truth matches one of the hashes.
   task send_random();
      logic [47:0] va;
      logic [47:0] truth;
      logic pt;
      logic [63:0] p;
      va = {16'($urandom), 32'($urandom)};
      pt = 1'($urandom_range(0, 1));
      truth = {16'($urandom), 32'($urandom)};
      if ($urandom_range(0, 2) != 0) begin
         p = sb.predict_addr(va, pt, $urandom_range(0, 7));
         truth = p[47:0];
      end
      send_request(va, pt, truth);
   endtask

   task end_phase();
      start <= 1'b0;
      @(posedge clock);
      drain();
   endtask

   initial begin
      logic [63:0] p;
      sb = new();
      sb.restore_defaults();
      sb.errors = 0;
      cycles = 0;
      burst_left = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_virtual_address <= '0;
      req_is_page_table <= 1'b0;
      req_true_physical_address <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes under the reset settings.
      send_request(48'h0, 1'b0, 48'h0);
      send_request('1, 1'b1, '1);
      send_request('1, 1'b0, 48'h0);
      p = sb.predict_addr(48'h1234_5678_9abc, 1'b0, 0);
      send_request(48'h1234_5678_9abc, 1'b0, p[47:0]);
      end_phase();

      // Most hashes, modulus and base of 2^35, spare kind code acts as both.
      set_config(8, PAGES_MAX, PAGES_MAX, KIND_SPARE, 1'b0, 1'b0);
      send_request('1, 1'b0, '1);
      send_request('1, 1'b1, 48'h0);
      end_phase();

      // Saturating hash count with zero user pages.
      set_config(15, 64'd0, 64'd5, KIND_BOTH, 1'b0, 1'b0);
      send_request(48'h0000_0020_1000, 1'b1, 48'h0);
      send_request(48'h7fff_ffff_f123, 1'b0, 48'h0);
      end_phase();

      // Zero hash count gives nothing.
      set_config(0, 64'd1, 64'd0, KIND_BOTH, 1'b0, 1'b0);
      send_request(48'h5555_5555_5555, 1'b0, 48'h0);
      end_phase();

      // Oracle, with page-table accesses filtered out.
      set_config(3, 64'd7, 64'd0, KIND_DATA_ONLY, 1'b1, 1'b1);
      send_request(48'h1, 1'b1, '1);
      send_request(48'h2, 1'b0, '1);
      send_request(48'h3, 1'b0, 48'h0);
      end_phase();

      // Perfect filter on page-table accesses only: one match, then none.
      set_config(8, 64'd1000, 64'd77, KIND_PT_ONLY, 1'b0, 1'b1);
      p = sb.predict_addr(48'habcd_ef01_2345, 1'b1, 5);
      send_request(48'habcd_ef01_2345, 1'b1, p[47:0]);
      send_request(48'habcd_ef01_2345, 1'b1, 48'h1);
      send_request(48'habcd_ef01_2345, 1'b0, p[47:0]);
      end_phase();

      // Random phases under random settings; the hold-off between them
      // lets every expected word arrive.
      for (int ph = 0; ph < 8; ph++) begin
         set_config($urandom_range(0, 15),
                    ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 9))
                       : 64'($urandom_range(1, 8)) << $urandom_range(0, 32),
                    64'($urandom_range(0, 32767)) << $urandom_range(0, 20),
                    2'($urandom_range(0, 3)),
                    ($urandom_range(0, 4) == 0),
                    1'($urandom_range(0, 1)));
         if (ph == 0) write_reg(REG_HASH_COUNT, 64'd8);
         for (int n = 0; n < 55; n++) send_random();
         end_phase();
      end

      while (sb.lines.size() > 0) begin
         sb.report("expected word never arrived");
         void'(sb.lines.pop_front());
      end
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
